// ===== design/lcb_pkg.sv =====
// ----------------------------------------------------------------------------
// Label bucketing package
// Shared types, codes and default sizes for the label to CSC bucketing block.
// ----------------------------------------------------------------------------
package lcb_pkg;

   // Default sizes of the stores.
   localparam int DEF_MAX_NODES    = 1024;
   localparam int DEF_MAX_CLUSTERS = 256;

   // Fixed field widths of the channels.
   localparam int KIND_W   = 2;
   localparam int LABEL_W  = 9;
   localparam int POS_W    = 11;
   localparam int VALUE_W  = 11;
   localparam int CCOUNT_W = 9;
   localparam int NCOUNT_W = 11;
   localparam int STATUS_W = 2;

   // Request kinds.
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD = 2'd0,
      KIND_COL  = 2'd1,
      KIND_SORT = 2'd2,
      KIND_NONE = 2'd3
   } lcb_kind_type;

   // Status codes of a result.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_LABEL = 2'd1,
      STATUS_FULL  = 2'd2,
      STATUS_RANGE = 2'd3
   } lcb_status_type;

   // Back end sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PRE_RD,
      ST_PRE_WR,
      ST_PRE_END,
      ST_NODE_RD,
      ST_NODE_CUR,
      ST_NODE_WR,
      ST_READ,
      ST_READ_RSP
   } lcb_state_type;

   // A classified command as it travels from front to back.
   typedef struct packed {
      lcb_kind_type       kind;
      logic               start_new;
      logic               bad_label;
      logic [LABEL_W-1:0] label;
      logic [POS_W-1:0]   position;
   } lcb_cmd_type;

endpackage

// ===== design/lcb_front.sv =====
// ----------------------------------------------------------------------------
// Label bucketing front end
// Accepts request beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module lcb_front #(
   parameter int MAX_CLUSTERS = lcb_pkg::DEF_MAX_CLUSTERS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [lcb_pkg::KIND_W-1:0]   req_kind,
   input  logic                         req_start_new,
   input  logic [lcb_pkg::LABEL_W-1:0]  req_label,
   input  logic [lcb_pkg::POS_W-1:0]    req_position,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output lcb_pkg::lcb_cmd_type         cmd
);

   lcb_pkg::lcb_cmd_type q_ff [2];
   lcb_pkg::lcb_cmd_type new_cmd;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;
   logic                 push, pop;

   // Classify the incoming beat.
   always_comb begin
      new_cmd.kind      = lcb_pkg::lcb_kind_type'(req_kind);
      new_cmd.start_new = req_start_new;
      new_cmd.bad_label = (req_label == '0) || (req_label > MAX_CLUSTERS);
      new_cmd.label     = req_label;
      new_cmd.position  = req_position;
   end

   assign req_ready = (count_ff != 2'd2);
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != 2'd0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[rd_ptr_ff];

   // Queue pointers and fill level.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== design/lcb_back.sv =====
// ----------------------------------------------------------------------------
// Label bucketing back end
// Executes loads, builds the column starts and sorted nodes, answers reads.
// ----------------------------------------------------------------------------
module lcb_back #(
   parameter int MAX_NODES    = lcb_pkg::DEF_MAX_NODES,
   parameter int MAX_CLUSTERS = lcb_pkg::DEF_MAX_CLUSTERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  lcb_pkg::lcb_cmd_type          cmd,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lcb_pkg::VALUE_W-1:0]   rsp_value,
   output logic [lcb_pkg::CCOUNT_W-1:0]  rsp_cluster_count,
   output logic [lcb_pkg::NCOUNT_W-1:0]  rsp_node_count,
   output logic [lcb_pkg::STATUS_W-1:0]  rsp_status
);

   localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
   localparam int CCW = $clog2(MAX_CLUSTERS + 1);
   localparam int NIW = $clog2(MAX_NODES);
   localparam int NCW = $clog2(MAX_NODES + 1);

   // Memories.
   logic [NCW-1:0] cnt_mem  [MAX_CLUSTERS];
   logic [NCW-1:0] col_mem  [MAX_CLUSTERS+1];
   logic [NCW-1:0] cur_mem  [MAX_CLUSTERS];
   logic [CIW-1:0] lab_mem  [MAX_NODES];
   logic [NIW-1:0] sort_mem [MAX_NODES];

   logic           cnt_we, col_we, cur_we, lab_we, sort_we;
   logic [CIW-1:0] cnt_waddr, cnt_raddr, cur_waddr, cur_raddr;
   logic [CCW-1:0] col_waddr, col_raddr;
   logic [NIW-1:0] lab_waddr, lab_raddr, sort_waddr, sort_raddr;
   logic [NCW-1:0] cnt_wdata, col_wdata, cur_wdata;
   logic [CIW-1:0] lab_wdata;
   logic [NIW-1:0] sort_wdata;
   logic [NCW-1:0] cnt_rd_ff, col_rd_ff, cur_rd_ff;
   logic [CIW-1:0] lab_rd_ff;
   logic [NIW-1:0] sort_rd_ff;

   // Control state.
   lcb_pkg::lcb_state_type  state_ff, state_in;
   lcb_pkg::lcb_cmd_type    cmd_ff, cmd_in;
   logic [NCW-1:0]          loaded_ff, loaded_in;
   logic [CCW-1:0]          largest_ff, largest_in;
   logic                    built_ff, built_in;
   logic [MAX_CLUSTERS-1:0] vld_ff, vld_in;
   logic [CCW-1:0]          idx_ff, idx_in;
   logic [NCW-1:0]          node_ff, node_in;
   logic [NCW-1:0]          sum_ff, sum_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [lcb_pkg::VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   lcb_pkg::lcb_status_type rsp_status_ff, rsp_status_in;

   logic [CIW-1:0] new_idx, cur_idx;
   logic [NCW-1:0] eff_loaded, old_cnt;

   assign new_idx = CIW'(cmd.label - 9'd1);
   assign cur_idx = CIW'(cmd_ff.label - 9'd1);
   assign cmd_ready = (state_ff == lcb_pkg::ST_IDLE) && !rsp_valid_ff;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = rsp_value_ff;
   assign rsp_cluster_count = lcb_pkg::CCOUNT_W'(largest_ff);
   assign rsp_node_count    = lcb_pkg::NCOUNT_W'(loaded_ff);
   assign rsp_status        = rsp_status_ff;

   // Sequencer: next state, memory controls and result beat.
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      loaded_in     = loaded_ff;
      largest_in    = largest_ff;
      built_in      = built_ff;
      vld_in        = vld_ff;
      idx_in        = idx_ff;
      node_in       = node_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      eff_loaded    = cmd.start_new ? '0 : loaded_ff;
      old_cnt       = vld_ff[cur_idx] ? cnt_rd_ff : '0;

      cnt_we     = 1'b0;
      cnt_waddr  = cur_idx;
      cnt_wdata  = old_cnt + 1'b1;
      cnt_raddr  = CIW'(idx_ff);
      col_we     = 1'b0;
      col_waddr  = idx_ff;
      col_wdata  = sum_ff;
      col_raddr  = CCW'(cmd_ff.position);
      cur_we     = 1'b0;
      cur_waddr  = CIW'(idx_ff);
      cur_wdata  = sum_ff;
      cur_raddr  = lab_rd_ff;
      lab_we     = 1'b0;
      lab_waddr  = NIW'(eff_loaded);
      lab_wdata  = new_idx;
      lab_raddr  = NIW'(node_ff);
      sort_we    = 1'b0;
      sort_waddr = NIW'(cur_rd_ff);
      sort_wdata = NIW'(node_ff);
      sort_raddr = NIW'(cmd_ff.position);

      unique case (state_ff)
         lcb_pkg::ST_IDLE: begin
            cnt_raddr = new_idx;
            if (cmd_valid && cmd_ready) begin
               cmd_in = cmd;
               unique case (cmd.kind)
                  lcb_pkg::KIND_LOAD: begin
                     if (cmd.start_new) begin
                        vld_in     = '0;
                        loaded_in  = '0;
                        largest_in = '0;
                        built_in   = 1'b0;
                     end
                     rsp_value_in = '0;
                     if (cmd.bad_label) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lcb_pkg::STATUS_LABEL;
                     end else if (eff_loaded >= MAX_NODES) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = lcb_pkg::STATUS_FULL;
                     end else begin
                        lab_we   = 1'b1;
                        state_in = lcb_pkg::ST_LOAD;
                     end
                  end
                  lcb_pkg::KIND_COL, lcb_pkg::KIND_SORT: begin
                     idx_in = '0;
                     sum_in = '0;
                     if (built_ff) begin
                        state_in = lcb_pkg::ST_READ;
                     end else if (largest_ff == '0) begin
                        state_in = lcb_pkg::ST_PRE_END;
                     end else begin
                        state_in = lcb_pkg::ST_PRE_RD;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_value_in  = '0;
                     rsp_status_in = lcb_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         // Count update of a load; an invalid count entry reads as zero.
         lcb_pkg::ST_LOAD: begin
            cnt_we          = 1'b1;
            vld_in[cur_idx] = 1'b1;
            loaded_in       = loaded_ff + 1'b1;
            if (cmd_ff.label > largest_ff) begin
               largest_in = CCW'(cmd_ff.label);
            end
            built_in      = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = lcb_pkg::STATUS_OK;
            state_in      = lcb_pkg::ST_IDLE;
         end
         lcb_pkg::ST_PRE_RD: begin
            state_in = lcb_pkg::ST_PRE_WR;
         end
         // Prefix sum: one column start and fill cursor per cluster.
         lcb_pkg::ST_PRE_WR: begin
            col_we = 1'b1;
            cur_we = 1'b1;
            sum_in = sum_ff + (vld_ff[CIW'(idx_ff)] ? cnt_rd_ff : '0);
            idx_in = CCW'(idx_ff + 1'b1);
            if (CCW'(idx_ff + 1'b1) == largest_ff) begin
               state_in = lcb_pkg::ST_PRE_END;
            end else begin
               state_in = lcb_pkg::ST_PRE_RD;
            end
         end
         lcb_pkg::ST_PRE_END: begin
            col_we    = 1'b1;
            col_waddr = largest_ff;
            node_in   = '0;
            if (loaded_ff == '0) begin
               built_in = 1'b1;
               state_in = lcb_pkg::ST_READ;
            end else begin
               state_in = lcb_pkg::ST_NODE_RD;
            end
         end
         lcb_pkg::ST_NODE_RD: begin
            state_in = lcb_pkg::ST_NODE_CUR;
         end
         lcb_pkg::ST_NODE_CUR: begin
            state_in = lcb_pkg::ST_NODE_WR;
         end
         // Place the node at its cluster's cursor and advance the cursor.
         lcb_pkg::ST_NODE_WR: begin
            sort_we   = 1'b1;
            cur_we    = 1'b1;
            cur_waddr = lab_rd_ff;
            cur_wdata = cur_rd_ff + 1'b1;
            node_in   = node_ff + 1'b1;
            if (NCW'(node_ff + 1'b1) == loaded_ff) begin
               built_in = 1'b1;
               state_in = lcb_pkg::ST_READ;
            end else begin
               state_in = lcb_pkg::ST_NODE_RD;
            end
         end
         lcb_pkg::ST_READ: begin
            state_in = lcb_pkg::ST_READ_RSP;
         end
         lcb_pkg::ST_READ_RSP: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = '0;
            rsp_status_in = lcb_pkg::STATUS_RANGE;
            if (cmd_ff.kind == lcb_pkg::KIND_COL) begin
               if (cmd_ff.position <= largest_ff) begin
                  rsp_value_in  = lcb_pkg::VALUE_W'(col_rd_ff);
                  rsp_status_in = lcb_pkg::STATUS_OK;
               end
            end else if (cmd_ff.position < loaded_ff) begin
               rsp_value_in  = lcb_pkg::VALUE_W'(sort_rd_ff);
               rsp_status_in = lcb_pkg::STATUS_OK;
            end
            state_in = lcb_pkg::ST_IDLE;
         end
         default: begin
            state_in = lcb_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lcb_pkg::ST_IDLE;
         loaded_ff    <= '0;
         largest_ff   <= '0;
         built_ff     <= 1'b0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         largest_ff   <= largest_in;
         built_ff     <= built_in;
         vld_ff       <= vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      node_ff       <= node_in;
      sum_ff        <= sum_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Memory ports, read data registered.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (col_we) begin
         col_mem[col_waddr] <= col_wdata;
      end
      if (cur_we) begin
         cur_mem[cur_waddr] <= cur_wdata;
      end
      if (lab_we) begin
         lab_mem[lab_waddr] <= lab_wdata;
      end
      if (sort_we) begin
         sort_mem[sort_waddr] <= sort_wdata;
      end
      cnt_rd_ff  <= cnt_mem[cnt_raddr];
      col_rd_ff  <= col_mem[col_raddr];
      cur_rd_ff  <= cur_mem[cur_raddr];
      lab_rd_ff  <= lab_mem[lab_raddr];
      sort_rd_ff <= sort_mem[sort_raddr];
   end

endmodule

// ===== design/label_to_csc_bucketing.sv =====
// ----------------------------------------------------------------------------
// Label to CSC bucketing
// Turns a stream of cluster labels into column starts and sorted node lists.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | kind, start_new, label, position
//  rsp     | out       | rsp_valid/rsp_ready  | value, cluster_count, node_count,
//          |           |                      | status
//
// A load passes the load state; a read of a built matrix the read and response
// states. The first read after loading builds first: read and write states per
// cluster up to the largest label, an end state, then node read, cursor read and
// write states per node. Reset is synchronous and needs no clearing pass.
// Requests queue two deep; the back end waits while a result beat is not taken.
// ----------------------------------------------------------------------------
module label_to_csc_bucketing #(
   parameter int MAX_NODES    = lcb_pkg::DEF_MAX_NODES,
   parameter int MAX_CLUSTERS = lcb_pkg::DEF_MAX_CLUSTERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [lcb_pkg::KIND_W-1:0]    req_kind,
   input  logic                          req_start_new,
   input  logic [lcb_pkg::LABEL_W-1:0]   req_label,
   input  logic [lcb_pkg::POS_W-1:0]     req_position,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [lcb_pkg::VALUE_W-1:0]   rsp_value,
   output logic [lcb_pkg::CCOUNT_W-1:0]  rsp_cluster_count,
   output logic [lcb_pkg::NCOUNT_W-1:0]  rsp_node_count,
   output logic [lcb_pkg::STATUS_W-1:0]  rsp_status
);

   logic                 cmd_valid;
   logic                 cmd_ready;
   lcb_pkg::lcb_cmd_type cmd;

   // Front end: classification and queue.
   lcb_front #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_kind      (req_kind),
      .req_start_new (req_start_new),
      .req_label     (req_label),
      .req_position  (req_position),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd)
   );

   // Back end: stores, build sequencer and result register.
   lcb_back #(
      .MAX_NODES    (MAX_NODES),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_valid         (cmd_valid),
      .cmd_ready         (cmd_ready),
      .cmd               (cmd),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_cluster_count (rsp_cluster_count),
      .rsp_node_count    (rsp_node_count),
      .rsp_status        (rsp_status)
   );

endmodule

// ===== dv/label_to_csc_bucketing_tb.sv =====
// ----------------------------------------------------------------------------
// Label to CSC bucketing testbench
// Drives loads, column reads and sorted reads through the request channel,
// predicts each result beat in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module label_to_csc_bucketing_tb;

   localparam int NODES    = lcb_pkg::DEF_MAX_NODES;
   localparam int CLUSTERS = lcb_pkg::DEF_MAX_CLUSTERS;
   localparam longint CYCLE_LIMIT = 3000000;

   // Expected result beat.
   typedef struct {
      logic [lcb_pkg::VALUE_W-1:0]  value;
      logic [lcb_pkg::CCOUNT_W-1:0] ccount;
      logic [lcb_pkg::NCOUNT_W-1:0] ncount;
      lcb_pkg::lcb_status_type      status;
   } csc_result_type;

   int error_count = 0;

   // Reports one mismatch and counts it.
   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      error_count++;
   endtask

   // Bucketing predictor holding its own copy of the stores.
   class csc_scoreboard;
      logic [7:0]     labels[NODES];
      int             counts[CLUSTERS];
      int             col_starts[CLUSTERS+1];
      int             sorted[NODES];
      int             loaded;
      int             largest;
      bit             built;
      csc_result_type pending[$];

      function void build_columns();
         int cursor[CLUSTERS];
         int sum;
         sum = 0;
         for (int c = 0; c < largest; c++) begin
            col_starts[c] = sum;
            cursor[c] = sum;
            sum += counts[c];
         end
         col_starts[largest] = sum;
         for (int n = 0; n < loaded; n++) begin
            sorted[cursor[labels[n]]] = n;
            cursor[labels[n]]++;
         end
         built = 1;
      endfunction

      function new();
         foreach (counts[i]) counts[i] = 0;
         loaded = 0;
         largest = 0;
         built = 0;
      endfunction

      // Notes an accepted request and queues its expected result.
      function void note_request(lcb_pkg::lcb_kind_type kind, bit start_new,
                                 int label, int position);
         csc_result_type r;
         r.value = '0;
         r.status = lcb_pkg::STATUS_OK;
         if (kind == lcb_pkg::KIND_LOAD) begin
            if (start_new) begin
               foreach (counts[i]) counts[i] = 0;
               loaded = 0;
               largest = 0;
               built = 0;
            end
            if (label == 0 || label > CLUSTERS) begin
               r.status = lcb_pkg::STATUS_LABEL;
            end else if (loaded >= NODES) begin
               r.status = lcb_pkg::STATUS_FULL;
            end else begin
               labels[loaded] = 8'(label - 1);
               counts[label-1]++;
               loaded++;
               if (label > largest) largest = label;
               built = 0;
            end
         end else if (kind == lcb_pkg::KIND_COL) begin
            if (!built) build_columns();
            if (position <= largest) r.value = lcb_pkg::VALUE_W'(col_starts[position]);
            else r.status = lcb_pkg::STATUS_RANGE;
         end else if (kind == lcb_pkg::KIND_SORT) begin
            if (!built) build_columns();
            if (position < loaded) r.value = lcb_pkg::VALUE_W'(sorted[position]);
            else r.status = lcb_pkg::STATUS_RANGE;
         end
         r.ccount = lcb_pkg::CCOUNT_W'(largest);
         r.ncount = lcb_pkg::NCOUNT_W'(loaded);
         pending.push_back(r);
      endfunction

      // Checks a result beat against the oldest expectation.
      task check_result(logic [lcb_pkg::VALUE_W-1:0] value,
                        logic [lcb_pkg::CCOUNT_W-1:0] ccount,
                        logic [lcb_pkg::NCOUNT_W-1:0] ncount,
                        logic [lcb_pkg::STATUS_W-1:0] status);
         csc_result_type r;
         if (pending.size() == 0) begin
            report_mismatch("result beat with nothing expected");
            return;
         end
         r = pending.pop_front();
         if (value !== r.value)
            report_mismatch($sformatf("value %0d, expected %0d", value, r.value));
         if (ccount !== r.ccount)
            report_mismatch($sformatf("cluster_count %0d, expected %0d", ccount, r.ccount));
         if (ncount !== r.ncount)
            report_mismatch($sformatf("node_count %0d, expected %0d", ncount, r.ncount));
         if (status !== r.status)
            report_mismatch($sformatf("status %0d, expected %0d", status, r.status));
      endtask
   endclass

   logic                         clock = 0;
   logic                         reset = 1;
   logic                         req_valid = 0;
   logic                         req_ready;
   logic [lcb_pkg::KIND_W-1:0]   req_kind = '0;
   logic                         req_start_new = 0;
   logic [lcb_pkg::LABEL_W-1:0]  req_label = '0;
   logic [lcb_pkg::POS_W-1:0]    req_position = '0;
   logic                         rsp_valid;
   logic                         rsp_ready = 0;
   logic [lcb_pkg::VALUE_W-1:0]  rsp_value;
   logic [lcb_pkg::CCOUNT_W-1:0] rsp_cluster_count;
   logic [lcb_pkg::NCOUNT_W-1:0] rsp_node_count;
   logic [lcb_pkg::STATUS_W-1:0] rsp_status;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   longint cycles = 0;
   csc_scoreboard board = new();

   label_to_csc_bucketing uut (.*);

   always #1 clock = ~clock;

   // Cycle counter guarding against a hang.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAIL label_to_csc_bucketing");
         $finish;
      end
   end

   // Result side: random back-pressure and checking of each beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_result(rsp_value, rsp_cluster_count, rsp_node_count, rsp_status);
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Sends one request beat, with a random gap first. Valid stays high after
   // the beat is taken until the next gap or drain lowers it.
   task automatic send_request(lcb_pkg::lcb_kind_type kind, bit start_new,
                               int label, int position);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_start_new <= start_new;
      req_label <= lcb_pkg::LABEL_W'(label);
      req_position <= lcb_pkg::POS_W'(position);
      do @(posedge clock); while (!req_ready);
      board.note_request(kind, start_new, label, position);
   endtask

   // Stops sending and waits until every expected beat has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   // One well-formed set: a fresh load followed by reads of its columns and nodes.
   task automatic random_set(int n_nodes, int max_label);
      int reads;
      for (int i = 0; i < n_nodes; i++)
         send_request(lcb_pkg::KIND_LOAD, i == 0, $urandom_range(max_label, 1),
                      $urandom_range(2047));
      reads = $urandom_range(12, 3);
      for (int i = 0; i < reads; i++) begin
         if ($urandom_range(1))
            send_request(lcb_pkg::KIND_COL, $urandom_range(1), $urandom_range(511),
                         $urandom_range(max_label + 1));
         else
            send_request(lcb_pkg::KIND_SORT, $urandom_range(1), $urandom_range(511),
                         $urandom_range(n_nodes));
      end
   endtask

   int sent;

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: empty reads, extremes of the fields and each special case.
      send_request(lcb_pkg::KIND_COL, 0, 0, 0);
      send_request(lcb_pkg::KIND_SORT, 0, 0, 0);
      send_request(lcb_pkg::KIND_LOAD, 1, 0, 0);
      send_request(lcb_pkg::KIND_LOAD, 0, 257, 2047);
      send_request(lcb_pkg::KIND_LOAD, 0, 511, 0);
      send_request(lcb_pkg::KIND_LOAD, 0, 256, 0);
      send_request(lcb_pkg::KIND_LOAD, 0, 1, 1024);
      send_request(lcb_pkg::KIND_LOAD, 0, 3, 0);
      send_request(lcb_pkg::KIND_LOAD, 0, 1, 0);
      send_request(lcb_pkg::KIND_COL, 1, 511, 0);
      send_request(lcb_pkg::KIND_COL, 0, 0, 256);
      send_request(lcb_pkg::KIND_COL, 0, 0, 257);
      send_request(lcb_pkg::KIND_COL, 0, 0, 2047);
      send_request(lcb_pkg::KIND_SORT, 0, 0, 3);
      send_request(lcb_pkg::KIND_SORT, 0, 0, 4);
      send_request(lcb_pkg::KIND_SORT, 0, 0, 2047);
      send_request(lcb_pkg::KIND_NONE, 1, 511, 2047);
      send_request(lcb_pkg::KIND_LOAD, 1, 0, 0);
      send_request(lcb_pkg::KIND_COL, 0, 0, 0);

      // Reads at the far ends of the node store.
      send_request(lcb_pkg::KIND_SORT, 0, 0, 1023);
      send_request(lcb_pkg::KIND_SORT, 0, 0, 1024);
      send_request(lcb_pkg::KIND_COL, 0, 0, board.largest);
      wait_drained();

      // Random part under three idling profiles.
      sent = 0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 49 : 0;
         recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 21 : 0;
         for (int s = 0; s < 14; s++) begin
            if ($urandom_range(9) == 0)
               send_request(lcb_pkg::lcb_kind_type'($urandom_range(3)), $urandom_range(1),
                            $urandom_range(511), $urandom_range(2047));
            else if ($urandom_range(5) == 0)
               random_set($urandom_range(5, 1), $urandom_range(4, 1));
            else
               random_set($urandom_range(24, 1),
                          $urandom_range(1) ? $urandom_range(8, 1) : CLUSTERS);
            if (s == 5) wait_drained();
         end
      end

      wait_drained();
      repeat (50) @(posedge clock);
      if (error_count == 0) begin
         $display("PASS label_to_csc_bucketing");
      end else begin
         $display("FAIL label_to_csc_bucketing");
      end
      $finish;
   end

endmodule
